[hdl/assert_macros.svh]
// Assertion shorthands, clocked on clk_i and off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge.
`define KSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define KSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/kse_pkg.sv]
package kse_pkg;

  localparam int WORD_LEN     = 3;
  localparam int MAX_KMER_LEN = 32;
  localparam int KMER_W       = 64;
  localparam int KLEN_W       = 6;
  localparam int KLEN_RESET   = 27;
  localparam int NBINS        = 1 << (2 * WORD_LEN);
  localparam int BIN_AW       = 2 * WORD_LEN;
  localparam int CNT_W        = 6;
  localparam int CNT_IW       = $clog2(MAX_KMER_LEN);
  localparam int WIN_W        = $clog2(MAX_KMER_LEN - WORD_LEN + 2);
  localparam int LG_FRAC      = 16;
  localparam int WLG_W        = 24;
  localparam int DLG_W        = 20;
  localparam int ACC_W        = WLG_W + 2;
  localparam int NUM_W        = WLG_W + 1;
  localparam int RND_SH       = 3;
  localparam int DIV_SH       = 4;
  localparam int DIV_W        = NUM_W - DIV_SH;
  localparam int STEP_W       = $clog2(DIV_W);
  localparam int OUT_W        = 15;
  localparam int OUT_MAX      = (1 << OUT_W) - 1;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  localparam logic CFG_IDX_KLEN = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } kse_state_e;

  typedef logic [WLG_W-1:0] wlg_tab_t [0:MAX_KMER_LEN];
  typedef logic [DLG_W-1:0] dlg_tab_t [0:MAX_KMER_LEN-1];

  // log2(v) with LG_FRAC fraction bits, fraction by repeated squaring
  function automatic logic [31:0] lg_q16(input int unsigned v);
    int unsigned n;
    logic [63:0] m;
    logic [31:0] frac;
    n    = 0;
    frac = '0;
    if (v == 0) begin
      return '0;
    end
    while (n < 31 && (v >> (n + 1)) != 0) begin
      n++;
    end
    m = 64'(v) << (30 - n);
    for (int i = 0; i < LG_FRAC; i++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 32'd1;
        m    = m >> 1;
      end
    end
    return (32'(n) << LG_FRAC) | frac;
  endfunction

  // (windows) * log2(K) for each K
  function automatic wlg_tab_t build_wlg();
    wlg_tab_t t;
    logic [63:0] p;
    for (int k = 0; k <= MAX_KMER_LEN; k++) begin
      if (k >= WORD_LEN) begin
        p    = 64'(k + 1 - WORD_LEN) * 64'(lg_q16(k));
        t[k] = p[WLG_W-1:0];
      end else begin
        t[k] = '0;
      end
    end
    return t;
  endfunction

  // growth of c*log2(c) when a bin goes from c to c+1
  function automatic dlg_tab_t build_dlg();
    dlg_tab_t t;
    logic [63:0] hi;
    logic [63:0] lo;
    for (int c = 0; c < MAX_KMER_LEN; c++) begin
      hi   = 64'(c + 1) * 64'(lg_q16(c + 1));
      lo   = 64'(c) * 64'(lg_q16(c));
      hi   = hi - lo;
      t[c] = hi[DLG_W-1:0];
    end
    return t;
  endfunction

  localparam wlg_tab_t WLG = build_wlg();
  localparam dlg_tab_t DLG = build_dlg();

endpackage

[hdl/kse_in_if.sv]
interface kse_in_if;
  import kse_pkg::*;

  logic              valid;
  logic              ready;
  logic [KMER_W-1:0] kmer_bits;

  modport source (output valid, output kmer_bits, input ready);
  modport sink (input valid, input kmer_bits, output ready);
endinterface

[hdl/kse_out_if.sv]
interface kse_out_if;
  import kse_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] entropy_q12;

  modport source (output valid, output entropy_q12, input ready);
  modport sink (input valid, input entropy_q12, output ready);
endinterface

[hdl/kse_ram.sv]
module kse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  // read during write returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/kmer_shannon_entropy_unit.sv]
// Port      Dir  Flow control       Word
// kmer_i    in   valid/ready        kmer_bits, 64-bit k-mer, 2 bits per base
// ent_o     out  valid/ready        entropy_q12, unsigned Q3.12 entropy
// apb       in   psel/penable, rdy  kmer_length at byte address 0
//
// An item (K = clamped kmer_length) runs K - 2 window counts through the 2-bit
// base shift register and the bin RAM, then drains, sets up, runs the bit-serial
// divider, loads the result and returns to idle.
// A K below the word length goes straight to the result.
// Reset is asynchronous; bins are tracked by 64 valid flags, no clearing pass.
// A result waits in the output register while the next word is accepted.
`include "assert_macros.svh"

module kmer_shannon_entropy_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kse_pkg::CFG_AW-1:0]  paddr,
  input  logic [kse_pkg::CFG_DW-1:0]  pwdata,
  output logic [kse_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  kse_in_if.sink                      kmer_i,
  kse_out_if.source                   ent_o
);
  import kse_pkg::*;

  kse_state_e state_q, state_d;

  logic [KLEN_W-1:0] klen_q;
  logic [KLEN_W-1:0] k_clamp;
  logic [KLEN_W-1:0] k_q;

  logic [KMER_W-1:0] sh_q, sh_d;
  logic [WIN_W-1:0]  win_cnt_q, win_cnt_d;

  logic              s2_vld_q;
  logic [BIN_AW-1:0] s2_addr_q;
  logic              wr_vld_q;
  logic [BIN_AW-1:0] wr_addr_q;
  logic [CNT_W-1:0]  wr_data_q;
  logic [NBINS-1:0]  bin_vld_q, bin_vld_d;
  logic [CNT_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  old_cnt;
  logic [CNT_W-1:0]  new_cnt;

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [NUM_W-1:0]  num_pos;
  logic [NUM_W-1:0]  n_sum;

  logic [DIV_W-1:0]  div_q, div_d;
  logic [CNT_IW-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KLEN_W-1:0] trial;
  logic              ge;

  logic              out_vld_q, out_vld_d;
  logic [OUT_W-1:0]  out_data_q;
  logic [OUT_W-1:0]  out_sat;

  logic in_rdy, in_acc, issue, prep_en, div_en, out_load;
  logic cfg_wr;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_KLEN);
  assign prdata = (paddr[2] == CFG_IDX_KLEN) ? CFG_DW'(klen_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KLEN_W'(KLEN_RESET);
    end else if (cfg_wr) begin
      klen_q <= pwdata[KLEN_W-1:0];
    end
  end

  assign k_clamp = (klen_q > KLEN_W'(MAX_KMER_LEN)) ? KLEN_W'(MAX_KMER_LEN) : klen_q;

  // ---------------- control ----------------
  assign kmer_i.ready = in_rdy;
  assign in_acc       = kmer_i.valid && in_rdy;

  always_comb begin
    in_rdy   = 1'b0;
    issue    = 1'b0;
    prep_en  = 1'b0;
    div_en   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_rdy   = 1'b1;
      ST_COUNT: issue    = (win_cnt_q != '0);
      ST_PREP:  prep_en  = 1'b1;
      ST_DIV:   div_en   = 1'b1;
      ST_DONE:  out_load = !out_vld_q || ent_o.ready;
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (kmer_i.valid) begin
          state_d = (k_clamp < KLEN_W'(WORD_LEN)) ? ST_DONE : ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (win_cnt_q == '0 && !s2_vld_q) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- window counting ----------------
  kse_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NBINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (s2_vld_q),
    .waddr_i (s2_addr_q),
    .wdata_i (new_cnt),
    .raddr_i (sh_q[BIN_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // forward the write of the previous cycle, mask bins not yet touched
  always_comb begin
    if (wr_vld_q && wr_addr_q == s2_addr_q) begin
      old_cnt = wr_data_q;
    end else if (bin_vld_q[s2_addr_q]) begin
      old_cnt = ram_rdata;
    end else begin
      old_cnt = '0;
    end
  end

  assign new_cnt = old_cnt + CNT_W'(1);

  always_comb begin
    sh_d      = sh_q;
    win_cnt_d = win_cnt_q;
    bin_vld_d = bin_vld_q;
    acc_d     = acc_q;
    if (in_acc) begin
      sh_d      = kmer_i.kmer_bits;
      win_cnt_d = (k_clamp >= KLEN_W'(WORD_LEN)) ?
                  WIN_W'(k_clamp - KLEN_W'(WORD_LEN - 1)) : '0;
      bin_vld_d = '0;
      acc_d     = ACC_W'(WLG[k_clamp]);
    end else begin
      if (issue) begin
        sh_d      = {2'b00, sh_q[KMER_W-1:2]};
        win_cnt_d = win_cnt_q - WIN_W'(1);
      end
      if (s2_vld_q) begin
        bin_vld_d[s2_addr_q] = 1'b1;
        acc_d = acc_q - ACC_W'(DLG[old_cnt[CNT_IW-1:0]]);
      end
    end
  end

  // ---------------- rounding and division ----------------
  assign num_pos = acc_q[ACC_W-1] ? '0 : acc_q[NUM_W-1:0];
  assign n_sum   = num_pos + (NUM_W'(k_q) << RND_SH);

  assign trial = {rem_q, div_q[DIV_W-1]};
  assign ge    = (trial >= k_q);

  always_comb begin
    div_d  = div_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (in_acc) begin
      div_d = '0;
    end else if (prep_en) begin
      div_d  = n_sum[NUM_W-1:DIV_SH];
      rem_d  = '0;
      step_d = STEP_W'(DIV_W - 1);
    end else if (div_en) begin
      div_d  = {div_q[DIV_W-2:0], ge};
      rem_d  = ge ? CNT_IW'(trial - k_q) : trial[CNT_IW-1:0];
      step_d = step_q - STEP_W'(1);
    end
  end

  // ---------------- output register ----------------
  assign out_sat = (div_q[DIV_W-1:OUT_W] != '0) ? OUT_W'(OUT_MAX) : div_q[OUT_W-1:0];

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (ent_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  assign ent_o.valid       = out_vld_q;
  assign ent_o.entropy_q12 = out_data_q;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      s2_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
      bin_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      s2_vld_q  <= issue;
      wr_vld_q  <= s2_vld_q;
      bin_vld_q <= bin_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q      <= sh_d;
    win_cnt_q <= win_cnt_d;
    acc_q     <= acc_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    step_q    <= step_d;
    s2_addr_q <= sh_q[BIN_AW-1:0];
    wr_addr_q <= s2_addr_q;
    wr_data_q <= new_cnt;
    if (in_acc) begin
      k_q <= k_clamp;
    end
    if (out_load) begin
      out_data_q <= out_sat;
    end
  end

  // ---------------- assertions ----------------
  `KSE_ASSERT(a_cnt_bound, s2_vld_q |-> (old_cnt < CNT_W'(MAX_KMER_LEN - WORD_LEN + 1)), "bin count exceeds window count")
  `KSE_ASSERT(a_div_clean, (state_q == ST_DIV) |-> (win_cnt_q == '0 && !s2_vld_q && !wr_vld_q), "division started with counting unfinished")
  `KSE_ASSERT(a_out_src, $rose(out_vld_q) |-> $past(state_q == ST_DONE), "result shown outside result load")
  `KSE_ASSERT_NEXT(a_acc_busy, in_acc, (state_q != ST_IDLE), "accepted word left the unit idle")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import kse_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int TAIL_CYCLES   = 60;
  localparam int MAX_PRINTS    = 20;
  localparam int CFG_IDX_SPARE = 1;
  localparam int N_PHASES      = 10;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  logic              in_valid = 1'b0;
  logic [KMER_W-1:0] in_bits = '0;
  logic              out_ready = 1'b0;

  kse_in_if  kin ();
  kse_out_if kout ();

  assign kin.valid     = in_valid;
  assign kin.kmer_bits = in_bits;
  assign kout.ready    = out_ready;

  kmer_shannon_entropy_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .kmer_i  (kin),
    .ent_o   (kout)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the kmer_length register
  logic [KLEN_W-1:0] klen_shadow = KLEN_RESET[KLEN_W-1:0];

  logic [KMER_W-1:0] kmer_pending [$];
  logic [OUT_W-1:0]  entropy_due [$];

  int unsigned errors = 0;
  int unsigned kmers_taken = 0;
  int unsigned entropies_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned long_holds = 0;
  int unsigned src_gap = 0;
  int unsigned snk_stall = 0;
  bit          src_steady = 1'b0;
  bit          snk_steady = 1'b0;
  bit          long_hold_req = 1'b0;
  bit          in_taken = 1'b0;

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // append a word to the tail of the send queue
  task automatic queue_kmer(input logic [KMER_W-1:0] w);
    kmer_pending = {kmer_pending, w};
  endtask

  // log2(v) with 16 fraction bits, fraction by repeated squaring of a Q30 mantissa
  function automatic longint unsigned fix_log2(input int unsigned v);
    int unsigned       top;
    longint unsigned   mant;
    longint unsigned   frac;
    top  = 0;
    frac = 0;
    if (v == 0) begin
      return 0;
    end
    while (top < 31 && (v >> (top + 1)) != 0) begin
      top++;
    end
    if (top > 30) begin
      return longint'(top) << 16;
    end
    mant = longint'(v) << (30 - top);
    repeat (16) begin
      mant = (mant * mant) >> 30;
      frac = frac << 1;
      if (mant >= 64'h8000_0000) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    return (longint'(top) << 16) | frac;
  endfunction

  // entropy of the word composition: (W*lg K - sum c*lg c) / K, rounded to Q12
  function automatic logic [OUT_W-1:0] entropy_q12_of(input logic [KMER_W-1:0] kmer,
                                                      input logic [KLEN_W-1:0] klen);
    int unsigned     k;
    int unsigned     wins;
    int unsigned     i;
    logic [CNT_W-1:0] hist [NBINS];
    logic [KMER_W-1:0] rest;
    longint          num;
    logic [63:0]     q;
    k = klen;
    if (k > MAX_KMER_LEN) begin
      k = MAX_KMER_LEN;
    end
    if (k < WORD_LEN) begin
      return '0;
    end
    wins = k + 1 - WORD_LEN;
    for (i = 0; i < NBINS; i++) begin
      hist[i] = '0;
    end
    rest = kmer;
    for (i = 0; i < wins; i++) begin
      hist[rest[BIN_AW-1:0]] = hist[rest[BIN_AW-1:0]] + 1'b1;
      rest = rest >> 2;
    end
    num = longint'(longint'(wins) * fix_log2(k));
    for (i = 0; i < NBINS; i++) begin
      if (hist[i] != 0) begin
        num = num - longint'(longint'(hist[i]) * fix_log2(hist[i]));
      end
    end
    if (num < 0) begin
      num = 0;
    end
    q = (64'(num) + 64'(8 * k)) / 64'(16 * k);
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end
    return q[OUT_W-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [KMER_W-1:0] random_kmer();
    int unsigned       r;
    int unsigned       period;
    int unsigned       i;
    logic [KMER_W-1:0] w;
    logic [9:0]        motif;
    r = $urandom_range(0, 9);
    w = {$urandom, $urandom};
    if (r >= 5 && r <= 6) begin
      // short repeat: few distinct words
      period = $urandom_range(1, 5);
      motif  = 10'($urandom);
      for (i = 0; i < KMER_W / 2; i++) begin
        w[2*i +: 2] = motif[2*(i % period) +: 2];
      end
    end else if (r >= 7 && r <= 8) begin
      // one base throughout with a few point changes
      motif = 10'($urandom);
      for (i = 0; i < KMER_W / 2; i++) begin
        w[2*i +: 2] = motif[1:0];
      end
      repeat ($urandom_range(1, 4)) begin
        w[2*$urandom_range(0, KMER_W / 2 - 1) +: 2] = 2'($urandom);
      end
    end else if (r == 9) begin
      w = w & {$urandom, $urandom};
    end
    return w;
  endfunction

  // input side: present queued words, hold until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_taken) begin
        // hold the current word
      end else if (src_gap > 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (kmer_pending.size() != 0) begin
        in_bits  <= kmer_pending.pop_front();
        in_valid <= 1'b1;
        src_gap  = src_steady ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random back-pressure plus one long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (snk_stall > 0) begin
        snk_stall--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        snk_stall     = LONG_HOLD - 1;
        long_holds++;
        out_ready <= 1'b0;
      end else if (snk_steady || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        snk_stall = pick_gap();
        out_ready <= 1'b0;
      end
    end
  end

  // monitor: predict on each accepted k-mer, check each delivered entropy
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    in_taken = in_valid && kin.ready;
    if (in_taken) begin
      entropy_due = {entropy_due, entropy_q12_of(in_bits, klen_shadow)};
      kmers_taken++;
    end
    if (rst_ni && kout.valid && out_ready) begin
      entropies_checked++;
      if (entropy_due.size() == 0) begin
        note_error($sformatf("entropy_q12 %0d with no k-mer outstanding", kout.entropy_q12));
      end else begin
        want = entropy_due.pop_front();
        if (kout.entropy_q12 !== want) begin
          note_error($sformatf("entropy_q12 got %0d want %0d", kout.entropy_q12, want));
        end
      end
    end
  end

  // watchdog: end the run after too long without any transfer
  always @(posedge clk_i) begin
    int unsigned quiet;
    if (!rst_ni || (in_valid && kin.ready) || (kout.valid && out_ready) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: %0d cycles without a transfer, %0d entropies outstanding",
                 quiet, entropy_due.size());
        $display("[kmer_shannon_entropy_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic apb_xfer(input bit wr, input int unsigned idx, input logic [CFG_DW-1:0] wdata,
                          output logic [CFG_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CFG_AW'(idx * 4);
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for the unit to go idle, write a register, read kmer_length back
  task automatic write_klen_reg(input int unsigned idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] rd;
    @(posedge clk_i);
    while (kmer_pending.size() != 0 || entropy_due.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    repeat (4) @(negedge clk_i);
    apb_xfer(1'b1, idx, value, rd);
    reg_writes++;
    if (idx == CFG_IDX_KLEN) begin
      klen_shadow = value[KLEN_W-1:0];
    end
    apb_xfer(1'b0, CFG_IDX_KLEN, '0, rd);
    if (rd !== CFG_DW'(klen_shadow)) begin
      note_error($sformatf("kmer_length reads %0d want %0d", rd, klen_shadow));
    end
  endtask

  initial begin
    logic [KLEN_W-1:0] phase_klen [N_PHASES];
    logic [KLEN_W-1:0] klen;
    int unsigned       n_items;
    phase_klen = '{6'd32, 6'd4, 6'd27, 6'd3, 6'd63, 6'd16, 6'd1, 6'd33, 6'd31, 6'd9};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset length first: uniform k-mers, some with alternating bits, and fully mixed ones
    queue_kmer('0);
    queue_kmer('1);
    queue_kmer(64'h5555_5555_5555_5555);
    queue_kmer(64'hAAAA_AAAA_AAAA_AAAA);
    queue_kmer(64'h0123_4567_89AB_CDEF);
    queue_kmer(64'hFEDC_BA98_7654_3210);

    write_klen_reg(CFG_IDX_KLEN, MAX_KMER_LEN);
    queue_kmer('0);
    queue_kmer('1);
    queue_kmer(64'h1B1B_1B1B_1B1B_1B1B);
    queue_kmer({$urandom, $urandom});

    // length of four; upper bits must be ignored
    write_klen_reg(CFG_IDX_KLEN, 32'hFFFF_FFC4);
    queue_kmer('0);
    queue_kmer(64'hFFFF_FFFF_FFFF_FF1B);
    queue_kmer(64'h0000_0000_0000_00E4);

    // a single window
    write_klen_reg(CFG_IDX_KLEN, WORD_LEN);
    queue_kmer(64'h3F);
    queue_kmer('1);

    // shorter than a word: no windows at all
    write_klen_reg(CFG_IDX_KLEN, 2);
    queue_kmer('1);
    write_klen_reg(CFG_IDX_KLEN, 1);
    queue_kmer(64'h0123_4567_89AB_CDEF);
    write_klen_reg(CFG_IDX_KLEN, 0);
    queue_kmer({$urandom, $urandom});

    // above the maximum: clamp
    write_klen_reg(CFG_IDX_KLEN, 63);
    queue_kmer('1);
    queue_kmer({$urandom, $urandom});

    // unmapped register: length must stay at 63
    write_klen_reg(CFG_IDX_SPARE, 5);
    queue_kmer(64'h0123_4567_89AB_CDEF);

    write_klen_reg(CFG_IDX_KLEN, 33);
    queue_kmer({$urandom, $urandom});

    for (int ph = 0; ph < N_PHASES; ph++) begin
      klen = (ph == N_PHASES - 1) ? KLEN_W'($urandom_range(0, 63)) : phase_klen[ph];
      // sender pauses here until every result is back
      write_klen_reg(CFG_IDX_KLEN, {26'($urandom), klen});
      src_steady = (ph % 3 == 0);
      snk_steady = (ph % 4 == 1);
      n_items    = $urandom_range(95, 111);
      repeat (n_items) queue_kmer(random_kmer());
      if (ph == 2) begin
        long_hold_req = 1'b1;
      end
    end

    @(posedge clk_i);
    while (kmer_pending.size() != 0 || entropy_due.size() != 0 || in_valid) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d k-mers and %0d entropies over %0d register writes",
             kmers_taken, entropies_checked, reg_writes);
    $display("lengths from 0 to 63 incl. clamped ones, %0d long output holds, %0d mismatches",
             long_holds, errors);
    if (errors == 0) begin
      $display("[kmer_shannon_entropy_unit] OK");
    end else begin
      $display("[kmer_shannon_entropy_unit] ERROR");
    end
    $finish;
  end

endmodule
